// ===== hw/rtl/cartridge_bank_mapper_top_defines.svh =====
// assertion macros for the cartridge bank mapper
`ifndef CARTRIDGE_BANK_MAPPER_TOP_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CBM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cbm_pkg.sv =====
`timescale 1ns / 1ps

package cbm_pkg;

    // cartridge ram size in bytes, a power of two
    localparam int RAM_BYTES = 32768;
    localparam int RAM_AW    = $clog2(RAM_BYTES);

    localparam int ROM_AW  = 23;
    localparam int RMASK_W = 15;
    localparam int QDEPTH  = 2;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // bus regions
    localparam logic [15:0] ADDR_RAMEN_LO = 16'h0000;
    localparam logic [15:0] ADDR_RAMEN_HI = 16'h1FFF;
    localparam logic [15:0] ADDR_BANKL_LO = 16'h2000;
    localparam logic [15:0] ADDR_BANKL_HI = 16'h2FFF;
    localparam logic [15:0] ADDR_BANKH_LO = 16'h3000;
    localparam logic [15:0] ADDR_BANKH_HI = 16'h3FFF;
    localparam logic [15:0] ADDR_RAMBK_LO = 16'h4000;
    localparam logic [15:0] ADDR_RAMBK_HI = 16'h5FFF;
    localparam logic [15:0] ADDR_ROM0_LO  = 16'h0000;
    localparam logic [15:0] ADDR_ROM0_HI  = 16'h3FFF;
    localparam logic [15:0] ADDR_ROMX_LO  = 16'h4000;
    localparam logic [15:0] ADDR_ROMX_HI  = 16'h7FFF;
    localparam logic [15:0] ADDR_XRAM_LO  = 16'hA000;
    localparam logic [15:0] ADDR_XRAM_HI  = 16'hBFFF;

    localparam logic [7:0] OPEN_BUS    = 8'hFF;
    localparam logic [3:0] RAM_EN_KEY  = 4'hA;

    // configuration register indexes
    localparam logic REG_ROM_MASK = 1'b0;
    localparam logic REG_RAM_MASK = 1'b1;

    localparam logic [ROM_AW-1:0]  ROM_MASK_RST = 23'h007FFF;
    localparam logic [RMASK_W-1:0] RAM_MASK_RST = 15'h7FFF;

    // one classified access, handed from front to back
    typedef struct packed {
        logic              ram_read;
        logic              ram_write;
        logic [RAM_AW-1:0] ram_idx;
        logic [7:0]        wdata;
        logic [7:0]        rd_const;
        logic              rom_fetch;
        logic [ROM_AW-1:0] rom_address;
    } t_op;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

// ===== hw/rtl/cbm_if.sv =====
`timescale 1ns / 1ps

// bus access word
interface cbm_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] bus_address;
    logic [7:0]  write_data;

    modport source (output valid, kind, bus_address, write_data, input ready);
    modport sink   (input valid, kind, bus_address, write_data, output ready);
endinterface

// result word
interface cbm_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        rom_fetch;
    logic [22:0] rom_address;

    modport source (output valid, read_data, rom_fetch, rom_address, input ready);
    modport sink   (input valid, read_data, rom_fetch, rom_address, output ready);
endinterface

// ===== hw/rtl/cbm_front.sv =====
`timescale 1ns / 1ps

module cbm_front
    import cbm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    cbm_req_if.sink            i_req,
    input  logic [ROM_AW-1:0]  i_rom_mask,
    input  logic [RMASK_W-1:0] i_ram_mask,
    input  t_q_stat            i_q_stat,
    input  t_back_stat         i_back_stat,
    output logic               o_push,
    output t_op                o_op
);

    logic       r_ram_en;
    logic [7:0] r_bank_lo;
    logic       r_bank_hi;
    logic [3:0] r_xram_page;
    logic       n_ram_en;
    logic [7:0] n_bank_lo;
    logic       n_bank_hi;
    logic [3:0] n_xram_page;

    logic [RMASK_W-1:0] ram_off;
    logic               accept;

    // take a word when the queue has room and the ram is not being cleared
    assign i_req.ready = !i_q_stat.full && !i_back_stat.clearing;
    assign accept      = i_req.valid && i_req.ready;
    assign o_push      = accept;

    // bank number times 0x2000 plus offset, masked to the ram size
    assign ram_off = {r_xram_page[1:0], i_req.bus_address[12:0]} & i_ram_mask;

    // classify the access
    always_comb begin
        o_op             = '0;
        o_op.ram_idx     = RAM_AW'(ram_off);
        o_op.wdata       = i_req.write_data;
        if (i_req.kind == KIND_READ) begin
            case (i_req.bus_address) inside
                [ADDR_ROM0_LO:ADDR_ROM0_HI]: begin
                    o_op.rom_fetch   = 1'b1;
                    o_op.rom_address = {9'd0, i_req.bus_address[13:0]} & i_rom_mask;
                end
                [ADDR_ROMX_LO:ADDR_ROMX_HI]: begin
                    o_op.rom_fetch   = 1'b1;
                    o_op.rom_address = {r_bank_hi, r_bank_lo, i_req.bus_address[13:0]}
                                       & i_rom_mask;
                end
                [ADDR_XRAM_LO:ADDR_XRAM_HI]: begin
                    o_op.ram_read = r_ram_en;
                    o_op.rd_const = r_ram_en ? 8'd0 : OPEN_BUS;
                end
                default: begin
                    o_op.rd_const = OPEN_BUS;
                end
            endcase
        end else begin
            case (i_req.bus_address) inside
                [ADDR_XRAM_LO:ADDR_XRAM_HI]: o_op.ram_write = r_ram_en;
                default:                     o_op.ram_write = 1'b0;
            endcase
        end
    end

    // mapper register writes
    always_comb begin
        n_ram_en    = r_ram_en;
        n_bank_lo   = r_bank_lo;
        n_bank_hi   = r_bank_hi;
        n_xram_page = r_xram_page;
        if (accept && i_req.kind == KIND_WRITE) begin
            case (i_req.bus_address) inside
                [ADDR_RAMEN_LO:ADDR_RAMEN_HI]:
                    n_ram_en = (i_req.write_data[3:0] == RAM_EN_KEY);
                [ADDR_BANKL_LO:ADDR_BANKL_HI]: n_bank_lo   = i_req.write_data;
                [ADDR_BANKH_LO:ADDR_BANKH_HI]: n_bank_hi   = i_req.write_data[0];
                [ADDR_RAMBK_LO:ADDR_RAMBK_HI]: n_xram_page = i_req.write_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_en    <= 1'b0;
            r_bank_lo   <= 8'd1;
            r_bank_hi   <= 1'b0;
            r_xram_page <= 4'd0;
        end else begin
            r_ram_en    <= n_ram_en;
            r_bank_lo   <= n_bank_lo;
            r_bank_hi   <= n_bank_hi;
            r_xram_page <= n_xram_page;
        end
    end

endmodule

// ===== hw/rtl/cbm_queue.sv =====
`timescale 1ns / 1ps

module cbm_queue
    import cbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_op     i_op,
    input  logic    i_pop,
    output t_op     o_op,
    output t_q_stat o_stat
);

    localparam int PW = $clog2(QDEPTH);

    t_op               r_slot [QDEPTH];
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [PW-1:0]     n_wp;
    logic [PW-1:0]     n_rp;
    logic [QCNT_W-1:0] n_cnt;

    assign o_op         = r_slot[r_rp];
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

    // pointer and fill count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

endmodule

// ===== hw/rtl/cbm_back.sv =====
`timescale 1ns / 1ps

module cbm_back
    import cbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_op,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output t_back_stat o_stat,
    cbm_rsp_if.source  o_rsp
);

    logic [7:0]        r_mem [RAM_BYTES];
    logic [7:0]        r_rd;
    logic              r_clearing;
    logic [RAM_AW-1:0] r_clr_cnt;
    logic              r_s1_valid;
    t_op               r_s1_op;
    logic              r_out_valid;
    logic [7:0]        r_out_rd;
    logic              r_out_fetch;
    logic [ROM_AW-1:0] r_out_raddr;
    logic              s1_move;

    assign o_stat.clearing = r_clearing;

    // stage one moves on when the output register is free or being taken
    assign s1_move = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign o_pop   = !i_q_stat.empty && !r_clearing && (!r_s1_valid || s1_move);

    // ram: clearing sweep after reset, then one access per word
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_cnt] <= 8'd0;
        end else if (o_pop && i_op.ram_write) begin
            r_mem[i_op.ram_idx] <= i_op.wdata;
        end
        if (o_pop) begin
            r_rd <= r_mem[i_op.ram_idx];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_cnt   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == RAM_AW'(RAM_BYTES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_op <= i_op;
        end
        if (s1_move) begin
            r_out_rd    <= r_s1_op.ram_read ? r_rd : r_s1_op.rd_const;
            r_out_fetch <= r_s1_op.rom_fetch;
            r_out_raddr <= r_s1_op.rom_address;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_out_rd;
    assign o_rsp.rom_fetch   = r_out_fetch;
    assign o_rsp.rom_address = r_out_raddr;

endmodule

// ===== hw/rtl/cartridge_bank_mapper_top.sv =====
// path: an accepted word goes through the queue, stage one and the output register
// throughput: one access word per cycle while results are taken (single ram port)
// reset: synchronous, active low; mapper registers return to bank 1, ram disabled
// after reset a clearing pass zeroes every ram byte; no access words are taken
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_top_defines.svh"

module cartridge_bank_mapper_top
    import cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbm_req_if.sink     i_req,
    cbm_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [ROM_AW-1:0]  r_rom_mask;
    logic [RMASK_W-1:0] r_ram_mask;
    logic               cfg_wr;
    logic               push;
    logic               pop;
    t_op                front_op;
    t_op                queue_op;
    t_q_stat            q_stat;
    t_back_stat         back_stat;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_mask <= ROM_MASK_RST;
            r_ram_mask <= RAM_MASK_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ROM_MASK: r_rom_mask <= pwdata[ROM_AW-1:0];
                REG_RAM_MASK: r_ram_mask <= pwdata[RMASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROM_MASK: prdata = {9'd0, r_rom_mask};
            REG_RAM_MASK: prdata = {17'd0, r_ram_mask};
            default:      prdata = 32'd0;
        endcase
    end

    // decode and mapper registers
    cbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_rom_mask  (r_rom_mask),
        .i_ram_mask  (r_ram_mask),
        .i_q_stat    (q_stat),
        .i_back_stat (back_stat),
        .o_push      (push),
        .o_op        (front_op)
    );

    // decoupling queue
    cbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (queue_op),
        .o_stat  (q_stat)
    );

    // ram access and result register
    cbm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (queue_op),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_stat   (back_stat),
        .o_rsp    (o_rsp)
    );

    // checks
    `CBM_ASSERT_NOW(a_no_accept_clear, i_clk, i_rst_n, back_stat.clearing, !i_req.ready, "word accepted during ram clear")
    `CBM_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, push, !q_stat.full || pop, "queue overflow")
    `CBM_ASSERT_NOW(a_rom_masked, i_clk, i_rst_n, o_rsp.valid, (o_rsp.rom_address & ~r_rom_mask) == '0, "rom address beyond mask")
    `CBM_ASSERT_NEXT(a_pop_fills_s1, i_clk, i_rst_n, pop && !o_rsp.ready && o_rsp.valid, !pop || o_rsp.valid, "pipeline lost result")

endmodule

// ===== sim/cbm_result_checker.sv =====
`timescale 1ns / 1ps

module cbm_result_checker
    import cbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbm_req_if          i_req,
    cbm_rsp_if          i_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [31:0] ROM_BANK_BYTES  = 32'h4000;
    localparam logic [31:0] XRAM_PAGE_BYTES = 32'h2000;

    typedef struct packed {
        logic [7:0]        read_data;
        logic              rom_fetch;
        logic [ROM_AW-1:0] rom_address;
    } t_bus_result;

    // mirror of the mapper registers and the cartridge ram
    logic [ROM_AW-1:0]  rom_mask;
    logic [RMASK_W-1:0] ram_mask;
    logic               ram_on;
    logic [7:0]         bank_lo;
    logic               bank_hi;
    logic [3:0]         xram_page;
    logic [7:0]         cart_ram [RAM_BYTES];
    t_bus_result        result_q [$];
    int                 fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = result_q.size();

    // byte index into the cartridge ram for an address in the external ram window
    function automatic int unsigned cart_ram_index(input logic [15:0] addr);
        logic [31:0] flat;
        flat = {28'd0, xram_page} * XRAM_PAGE_BYTES
             + ({16'd0, addr} - {16'd0, ADDR_XRAM_LO});
        flat = flat & {17'd0, ram_mask};
        return flat % RAM_BYTES;
    endfunction

    // one bus access: update the mirror and work out the result word
    function automatic t_bus_result apply_access(input logic kind, input logic [15:0] addr,
                                                 input logic [7:0] data);
        t_bus_result r;
        logic [31:0] flat;
        logic        in_xram;
        r       = '0;
        in_xram = (addr >= ADDR_XRAM_LO) && (addr <= ADDR_XRAM_HI);
        if (kind == KIND_READ) begin
            if (addr <= ADDR_ROM0_HI) begin
                r.rom_fetch   = 1'b1;
                r.rom_address = {{(ROM_AW-16){1'b0}}, addr} & rom_mask;
            end else if (addr <= ADDR_ROMX_HI) begin
                flat = {23'd0, bank_hi, bank_lo} * ROM_BANK_BYTES
                     + ({16'd0, addr} - {16'd0, ADDR_ROMX_LO});
                r.rom_fetch   = 1'b1;
                r.rom_address = flat[ROM_AW-1:0] & rom_mask;
            end else if (in_xram) begin
                r.read_data = ram_on ? cart_ram[cart_ram_index(addr)] : OPEN_BUS;
            end else begin
                r.read_data = OPEN_BUS;
            end
        end else begin
            if (addr <= ADDR_RAMEN_HI) begin
                ram_on = (data[3:0] == RAM_EN_KEY);
            end else if (addr <= ADDR_BANKL_HI) begin
                bank_lo = data;
            end else if (addr <= ADDR_BANKH_HI) begin
                bank_hi = data[0];
            end else if (addr <= ADDR_RAMBK_HI) begin
                xram_page = data[3:0];
            end else if (in_xram && ram_on) begin
                cart_ram[cart_ram_index(addr)] = data;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_bus_result want;
        if (!i_rst_n) begin
            rom_mask  = ROM_MASK_RST;
            ram_mask  = RAM_MASK_RST;
            ram_on    = 1'b0;
            bank_lo   = 8'd1;
            bank_hi   = 1'b0;
            xram_page = 4'd0;
            for (int i = 0; i < RAM_BYTES; i++) cart_ram[i] = 8'd0;
            result_q.delete();
        end else begin
            // register writes on the configuration port
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                case (paddr[2])
                    REG_ROM_MASK: rom_mask = pwdata[ROM_AW-1:0];
                    REG_RAM_MASK: ram_mask = pwdata[RMASK_W-1:0];
                    default: ;
                endcase
            end

            // result word against the oldest expectation
            if (i_rsp.valid && i_rsp.ready) begin
                if (result_q.size() == 0) begin
                    $error("result word with no access waiting");
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    if (i_rsp.read_data !== want.read_data) begin
                        $error("read_data: expected %0h, got %0h",
                               want.read_data, i_rsp.read_data);
                        fails++;
                    end
                    if (i_rsp.rom_fetch !== want.rom_fetch) begin
                        $error("rom_fetch: expected %0h, got %0h",
                               want.rom_fetch, i_rsp.rom_fetch);
                        fails++;
                    end
                    if (i_rsp.rom_address !== want.rom_address) begin
                        $error("rom_address: expected %0h, got %0h",
                               want.rom_address, i_rsp.rom_address);
                        fails++;
                    end
                end
            end

            // accepted access word
            if (i_req.valid && i_req.ready)
                result_q.push_back(apply_access(i_req.kind, i_req.bus_address,
                                                i_req.write_data));
        end
    end

endmodule

// ===== sim/tb_cartridge_bank_mapper_top.sv =====
`timescale 1ns / 1ps

module tb_cartridge_bank_mapper_top
    import cbm_pkg::*;
;

    localparam int LONG_HOLD      = 40;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 150000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          stuck_cycles = 0;
    bit          steady_flow  = 1'b0;
    bit          hold_long    = 1'b0;

    cbm_req_if access_ch ();
    cbm_rsp_if result_ch ();

    cartridge_bank_mapper_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (access_ch),
        .o_rsp   (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cbm_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (access_ch),
        .i_rsp        (result_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((access_ch.valid && access_ch.ready) || (result_ch.valid && result_ch.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("cartridge_bank_mapper_top test failed");
            $finish;
        end
    end

    // result receiver: random stalls, one long hold on request
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_long = 1'b0;
            end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // offer one access word, with an occasional idle burst ahead of it
    task automatic send_access(input logic kind, input logic [15:0] addr,
                               input logic [7:0] data);
        if (!steady_flow && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 5)) begin
                @(negedge i_clk);
                access_ch.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        access_ch.valid       <= 1'b1;
        access_ch.kind        <= kind;
        access_ch.bus_address <= addr;
        access_ch.write_data  <= data;
        do @(posedge i_clk); while (access_ch.ready !== 1'b1);
    endtask

    // stop offering and wait until every expected word has come back
    task automatic drain();
        @(negedge i_clk);
        access_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // new rom and ram sizes, only with the block idle
    task automatic set_sizes(input logic [31:0] rom_mask, input logic [31:0] ram_mask);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_write(REG_ROM_MASK, rom_mask);
        apb_write(REG_RAM_MASK, ram_mask);
    endtask

    // mostly well-formed mapper traffic, some noise
    task automatic random_access();
        int          pick;
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  data;
        pick = $urandom_range(0, 99);
        kind = KIND_WRITE;
        data = 8'($urandom_range(0, 255));
        if (pick < 10) begin
            addr = 16'($urandom_range(ADDR_RAMEN_LO, ADDR_RAMEN_HI));
            if ($urandom_range(0, 3) != 0) data[3:0] = RAM_EN_KEY;
        end else if (pick < 18) begin
            addr = 16'($urandom_range(ADDR_BANKL_LO, ADDR_BANKL_HI));
        end else if (pick < 23) begin
            addr = 16'($urandom_range(ADDR_BANKH_LO, ADDR_BANKH_HI));
        end else if (pick < 30) begin
            addr = 16'($urandom_range(ADDR_RAMBK_LO, ADDR_RAMBK_HI));
        end else if (pick < 42) begin
            kind = KIND_READ;
            addr = 16'($urandom_range(ADDR_ROM0_LO, ADDR_ROMX_HI));
        end else if (pick < 84) begin
            // external ram, half the time in a small window so reads hit writes
            if (pick >= 62) kind = KIND_READ;
            if ($urandom_range(0, 1) == 0)
                addr = ADDR_XRAM_LO + 16'($urandom_range(0, 15));
            else
                addr = 16'($urandom_range(ADDR_XRAM_LO, ADDR_XRAM_HI));
        end else begin
            kind = 1'($urandom_range(0, 1));
            addr = 16'($urandom_range(0, 16'hFFFF));
        end
        send_access(kind, addr, data);
    endtask

    // stimulus
    initial begin : stimulus
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        access_ch.valid       = 1'b0;
        access_ch.kind        = KIND_READ;
        access_ch.bus_address = '0;
        access_ch.write_data  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: regions, bank extremes, ram enable and disabled ram
        send_access(KIND_READ,  16'h0000, 8'h00);
        send_access(KIND_READ,  16'h3FFF, 8'hFF);
        send_access(KIND_READ,  16'h4000, 8'h00);
        send_access(KIND_READ,  16'h7FFF, 8'h00);
        send_access(KIND_READ,  16'hA000, 8'h00);
        send_access(KIND_WRITE, 16'hA000, 8'h55);
        send_access(KIND_READ,  16'h8000, 8'h00);
        send_access(KIND_READ,  16'hFFFF, 8'h00);
        send_access(KIND_WRITE, 16'hC000, 8'h77);
        send_access(KIND_WRITE, 16'h1FFF, 8'h0A);
        send_access(KIND_READ,  16'hA000, 8'h00);
        send_access(KIND_WRITE, 16'hBFFF, 8'hFF);
        send_access(KIND_READ,  16'hBFFF, 8'h00);
        send_access(KIND_WRITE, 16'h2000, 8'h00);
        send_access(KIND_READ,  16'h4000, 8'h00);
        send_access(KIND_WRITE, 16'h2FFF, 8'hFF);
        send_access(KIND_WRITE, 16'h3000, 8'h01);
        send_access(KIND_READ,  16'h7FFF, 8'h00);
        send_access(KIND_WRITE, 16'h4000, 8'h0F);
        send_access(KIND_WRITE, 16'hA123, 8'hA5);
        send_access(KIND_READ,  16'hA123, 8'h00);
        send_access(KIND_WRITE, 16'h6000, 8'h12);
        send_access(KIND_WRITE, 16'h0000, 8'h1A);
        send_access(KIND_WRITE, 16'h1000, 8'hA0);
        send_access(KIND_READ,  16'hA123, 8'h00);

        // largest sizes, with the receiver holding off at the start
        set_sizes(32'h7FFFFF, 32'h7FFF);
        hold_long = 1'b1;
        repeat (140) random_access();

        // smallest sizes
        set_sizes(32'h0, 32'h0);
        repeat (100) random_access();

        set_sizes(32'h1FFFF, 32'h7FF);
        repeat (70) random_access();
        hold_long = 1'b1;
        repeat (70) random_access();

        set_sizes((32'd1 << $urandom_range(0, 23)) - 1, (32'd1 << $urandom_range(0, 15)) - 1);
        repeat (140) random_access();

        // last part at full rate on both sides
        set_sizes(32'h3FFFFF, 32'h1FFF);
        steady_flow = 1'b1;
        repeat (200) random_access();

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("cartridge_bank_mapper_top test passed");
        else
            $display("cartridge_bank_mapper_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_if.sv
hw/rtl/cbm_front.sv
hw/rtl/cbm_queue.sv
hw/rtl/cbm_back.sv
hw/rtl/cartridge_bank_mapper_top.sv
sim/cbm_result_checker.sv
sim/tb_cartridge_bank_mapper_top.sv
